FILE: hw/rtl/terrain_snow_cover_cell_unit_defines.svh
// Assertion helpers for the snow cover cell unit.
// Both expect clk and rst_n in scope.
`ifndef TERRAIN_SNOW_COVER_CELL_UNIT_DEFINES_SVH
`define TERRAIN_SNOW_COVER_CELL_UNIT_DEFINES_SVH

// Same-cycle implication.
`define TSCC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TSCC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/tscc_pkg.sv
package tscc_pkg;

    localparam int MAX_DEPTH_UNITS = 66;
    localparam int AFFECT_HEIGHT   = 1;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_TEMP       = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_DROP       = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SNOW_TEMP       = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSITION_W    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACCUM_SLOPE     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STABLE      = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SHELTER_STRENGTH = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PRECIPITATION   = 4'd7;

    // Divider geometry: 16 fraction bits, four bits per stage
    localparam int DEN_W          = 15;
    localparam int Q_W            = 16;
    localparam int BITS_PER_STAGE = 4;
    localparam int DIV_STAGES     = Q_W / BITS_PER_STAGE;

    // Accept edge to result strobe
    localparam int PIPE_LAT = 15;

    typedef struct packed {
        logic signed [15:0] height_sample;
        logic [14:0]        slope_angle;
        logic signed [15:0] concavity_value;
    } cell_item_t;

    typedef struct packed {
        logic signed [17:0] cell_temp;
        logic [15:0]        snow_cover;
        logic [14:0]        snow_depth;
        logic signed [15:0] new_height;
    } cell_result_t;

    // Register values with the range limits already applied
    typedef struct packed {
        logic signed [15:0] base_temp;
        logic [15:0]        temp_drop;
        logic signed [13:0] snow_temp;
        logic [DEN_W-1:0]   trans_w;
        logic [14:0]        accum_slope;
        logic [DEN_W-1:0]   slope_span;
        logic [15:0]        shelter_strength;
        logic [15:0]        precipitation;
    } cfg_t;

endpackage

FILE: hw/rtl/tscc_cfg_regs.sv
module tscc_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tscc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tscc_pkg::CFG_DATA_W-1:0] cfg_data,
    output tscc_pkg::cfg_t                  cfg
);
    import tscc_pkg::*;

    logic [15:0] base_temp_reg;
    logic [15:0] temp_drop_reg;
    logic [13:0] snow_temp_reg;
    logic [12:0] trans_w_reg;
    logic [14:0] accum_reg;
    logic [14:0] max_stable_reg;
    logic [15:0] shelter_reg;
    logic [15:0] precip_reg;

    logic [14:0] max_eff;
    logic [14:0] accum_eff;
    logic [14:0] span_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_temp_reg  <= 16'd3072;
            temp_drop_reg  <= 16'd16640;
            snow_temp_reg  <= 14'd384;
            trans_w_reg    <= 13'd1024;
            accum_reg      <= 15'd5632;
            max_stable_reg <= 15'd12288;
            shelter_reg    <= 16'd29491;
            precip_reg     <= 16'd52429;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BASE_TEMP:        base_temp_reg  <= cfg_data;
                REG_TEMP_DROP:        temp_drop_reg  <= cfg_data;
                REG_SNOW_TEMP:        snow_temp_reg  <= cfg_data[13:0];
                REG_TRANSITION_W:     trans_w_reg    <= cfg_data[12:0];
                REG_ACCUM_SLOPE:      accum_reg      <= cfg_data[14:0];
                REG_MAX_STABLE:       max_stable_reg <= cfg_data[14:0];
                REG_SHELTER_STRENGTH: shelter_reg    <= cfg_data;
                REG_PRECIPITATION:    precip_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp slope limits and keep the span at least one degree
    always_comb
    begin
        if (max_stable_reg < 15'd256)
            max_eff = 15'd256;
        else if (max_stable_reg > 15'd22784)
            max_eff = 15'd22784;
        else
            max_eff = max_stable_reg;
        accum_eff = (accum_reg > max_eff) ? max_eff : accum_reg;
        span_raw  = max_eff - accum_eff;
    end

    assign cfg.base_temp        = base_temp_reg;
    assign cfg.temp_drop        = temp_drop_reg;
    assign cfg.snow_temp        = snow_temp_reg;
    assign cfg.trans_w          = (trans_w_reg < 13'd26) ? DEN_W'(26)
                                                         : DEN_W'(trans_w_reg);
    assign cfg.accum_slope      = accum_eff;
    assign cfg.slope_span       = (span_raw < 15'd256) ? DEN_W'(256) : DEN_W'(span_raw);
    assign cfg.shelter_strength = shelter_reg;
    assign cfg.precipitation    = precip_reg;

endmodule

FILE: hw/rtl/tscc_frac_div.sv
// Pipelined restoring divider: quo = floor(num * 2^Q_W / den), valid for num < den.
module tscc_frac_div (
    input  logic                        clk,
    input  logic [tscc_pkg::DEN_W-1:0]  num,
    input  logic [tscc_pkg::DEN_W-1:0]  den,
    output logic [tscc_pkg::Q_W-1:0]    quo
);
    import tscc_pkg::*;

    logic [DEN_W-1:0] rem_reg [DIV_STAGES];
    logic [Q_W-1:0]   quo_reg [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        logic [DEN_W-1:0] r_in;
        logic [Q_W-1:0]   q_in;
        logic [DEN_W-1:0] r_next;
        logic [Q_W-1:0]   q_next;

        if (s == 0)
        begin : g_first
            assign r_in = num;
            assign q_in = '0;
        end
        else
        begin : g_rest
            assign r_in = rem_reg[s-1];
            assign q_in = quo_reg[s-1];
        end

        always_comb
        begin
            logic [DEN_W:0] t;
            r_next = r_in;
            q_next = q_in;
            for (int k = 0; k < BITS_PER_STAGE; k++)
            begin
                t = {r_next, 1'b0};
                if (t >= {1'b0, den})
                begin
                    t      = t - {1'b0, den};
                    q_next = {q_next[Q_W-2:0], 1'b1};
                end
                else
                begin
                    q_next = {q_next[Q_W-2:0], 1'b0};
                end
                r_next = t[DEN_W-1:0];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s] <= r_next;
            quo_reg[s] <= q_next;
        end
    end

    assign quo = quo_reg[DIV_STAGES-1];

endmodule

FILE: hw/rtl/tscc_smooth.sv
// Smoothstep 3t^2 - 2t^3 in Q16, two register stages.
module tscc_smooth (
    input  logic        clk,
    input  logic [16:0] u,
    output logic [16:0] s
);
    logic        full_reg;
    logic [31:0] sq_reg;
    logic [17:0] w_reg;
    logic [16:0] s_reg;
    logic [49:0] prod;

    always_ff @(posedge clk)
    begin
        full_reg <= u[16];
        sq_reg   <= u[15:0] * u[15:0];
        w_reg    <= 18'd196608 - {1'b0, u[15:0], 1'b0};
    end

    assign prod = sq_reg * w_reg;

    always_ff @(posedge clk)
    begin
        s_reg <= full_reg ? 17'd65536 : prod[48:32];
    end

    assign s = s_reg;

endmodule

FILE: hw/rtl/terrain_snow_cover_cell_unit.sv
// Each accepted cell yields its result, with done high, from the final result register.
// Throughput: one cell per cycle; busy never rises, so start may stay high.
// Depth is set by the two 4-stage fraction dividers and the multiply chain behind them.
// Reset clears the valid pipeline and loads the register defaults; data stages are not reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "terrain_snow_cover_cell_unit_defines.svh"

module terrain_snow_cover_cell_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  tscc_pkg::cell_item_t            item,
    output logic                            done,
    output tscc_pkg::cell_result_t          result,
    input  logic                            cfg_we,
    input  logic [tscc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tscc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tscc_pkg::*;

    // Side data that rides along with the dividers and multiply chain
    typedef struct packed {
        logic               pos;
        logic signed [15:0] h;
        logic signed [17:0] temp;
        logic               cneg;
        logic               cge;
        logic               sneg;
        logic               sge;
        logic [31:0]        shprod;
        logic [16:0]        shelter;
    } aux_t;

    localparam int AUX_LEN = 11;

    cfg_t cfg;

    logic [PIPE_LAT:1] vld_reg;
    logic              accept;

    logic signed [15:0] s1_h_reg, s1_conc_reg;
    logic [14:0]        s1_slope_reg;

    logic signed [32:0] s2_dprod_reg;
    logic signed [31:0] s2_cprod_reg;
    logic signed [15:0] s2_h_reg;
    logic [14:0]        s2_slope_reg;

    logic signed [17:0] s3_temp_reg;
    logic signed [18:0] s3_cnum_reg;
    logic signed [15:0] s3_snum_reg;
    logic [15:0]        s3_inner_reg;
    logic signed [15:0] s3_h_reg;

    logic [DEN_W-1:0]   c_num_reg, s_num_reg;
    aux_t               aux_reg [AUX_LEN];
    aux_t               aux_next;
    aux_t               aux1_next;

    logic [Q_W-1:0]     c_quo, s_quo;
    logic [16:0]        u_c_reg, u_s_reg;
    logic [16:0]        sm_c, sm_s;

    logic [16:0]        p1_reg, p2_reg;
    logic [15:0]        p3_reg;
    logic [33:0]        p1_full, p2_full, p3_full;
    logic [16:0]        stable;

    cell_result_t       result_reg, result_next;
    logic               result_pos_reg;

    // Derived values for stages 3, 4 and 15
    logic signed [32:0] drop_full;
    logic signed [17:0] drop18;
    logic signed [18:0] cbase;
    logic signed [31:0] inner_off;
    logic [18:0]        cmag;
    logic [31:0]        depth_prod;
    logic [15:0]        depth16;
    logic [14:0]        depth;
    logic signed [16:0] hsum;

    tscc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The pipeline never stalls, so the unit is always ready for the next item
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[PIPE_LAT-1:1], accept};
    end

    // Stage 1: capture the cell
    always_ff @(posedge clk)
    begin
        s1_h_reg     <= item.height_sample;
        s1_slope_reg <= item.slope_angle;
        s1_conc_reg  <= item.concavity_value;
    end

    // Stage 2: height lapse product and concavity shelter product
    always_ff @(posedge clk)
    begin
        s2_dprod_reg <= $signed({1'b0, cfg.temp_drop}) * s1_h_reg;
        s2_cprod_reg <= 32'(s1_conc_reg * 17'sd29491);
        s2_h_reg     <= s1_h_reg;
        s2_slope_reg <= s1_slope_reg;
    end

    // Stage 3: round the drop, form temperature, the cold and slope numerators and the inner shelter term
    assign drop_full = (s2_dprod_reg + 33'sd16384) >>> 15;
    assign drop18    = drop_full[17:0];
    assign cbase     = 19'(cfg.snow_temp) - 19'(cfg.base_temp);
    assign inner_off = s2_cprod_reg >>> 15;

    always_ff @(posedge clk)
    begin
        s3_temp_reg  <= 18'(cfg.base_temp) - drop18;
        s3_cnum_reg  <= cbase + 19'(drop18);
        s3_snum_reg  <= $signed({1'b0, s2_slope_reg}) - $signed({1'b0, cfg.accum_slope});
        s3_inner_reg <= 16'(32'sd36045 + inner_off);
        s3_h_reg     <= s2_h_reg;
    end

    // Stage 4: sign/magnitude split, range flags for both ratios and the shelter product
    assign cmag = s3_cnum_reg[18] ? 19'(-s3_cnum_reg) : 19'(s3_cnum_reg);

    always_comb
    begin
        aux_next.pos     = !s3_h_reg[15] && (s3_h_reg != 16'sd0);
        aux_next.h       = s3_h_reg;
        aux_next.temp    = s3_temp_reg;
        aux_next.cneg    = s3_cnum_reg[18];
        aux_next.cge     = cmag >= 19'(cfg.trans_w);
        aux_next.sneg    = s3_snum_reg[15] || (s3_snum_reg == 16'sd0);
        aux_next.sge     = !s3_snum_reg[15] && (s3_snum_reg[14:0] >= cfg.slope_span);
        aux_next.shprod  = (17'd65536 - {1'b0, s3_inner_reg}) * cfg.shelter_strength;
        aux_next.shelter = '0;
    end

    // Finish the shelter blend in the stage after its product
    always_comb
    begin
        aux1_next         = aux_reg[0];
        aux1_next.shelter = 17'd65536 - {1'b0, aux_reg[0].shprod[31:16]};
    end

    always_ff @(posedge clk)
    begin
        c_num_reg <= cmag[DEN_W-1:0];
        s_num_reg <= s3_snum_reg[DEN_W-1:0];
        aux_reg[0] <= aux_next;
        aux_reg[1] <= aux1_next;
        for (int k = 2; k < AUX_LEN; k++)
            aux_reg[k] <= aux_reg[k-1];
    end

    // Stages 5 to 8: both ratio divisions
    tscc_frac_div u_div_cold (
        .clk (clk),
        .num (c_num_reg),
        .den (cfg.trans_w),
        .quo (c_quo)
    );

    tscc_frac_div u_div_slope (
        .clk (clk),
        .num (s_num_reg),
        .den (cfg.slope_span),
        .quo (s_quo)
    );

    // Stage 9: apply the half offset to the cold ratio and clamp each ratio to [0, 1]
    always_ff @(posedge clk)
    begin
        if (aux_reg[4].cge)
            u_c_reg <= aux_reg[4].cneg ? 17'd0 : 17'd65536;
        else if (aux_reg[4].cneg)
            u_c_reg <= (c_quo > 16'd32768) ? 17'd0 : 17'd32768 - {1'b0, c_quo};
        else
            u_c_reg <= (c_quo >= 16'd32768) ? 17'd65536 : 17'd32768 + {1'b0, c_quo};

        if (aux_reg[4].sneg)
            u_s_reg <= 17'd0;
        else if (aux_reg[4].sge)
            u_s_reg <= 17'd65536;
        else
            u_s_reg <= {1'b0, s_quo};
    end

    // Stages 10 and 11: smoothstep of both ratios
    tscc_smooth u_smooth_cold (
        .clk (clk),
        .u   (u_c_reg),
        .s   (sm_c)
    );

    tscc_smooth u_smooth_slope (
        .clk (clk),
        .u   (u_s_reg),
        .s   (sm_s)
    );

    // Stages 12 to 14: potential = cold * stable * shelter * precipitation
    assign stable  = 17'd65536 - sm_s;
    assign p1_full = sm_c * stable;
    assign p2_full = p1_reg * aux_reg[8].shelter;
    assign p3_full = p2_reg * {1'b0, cfg.precipitation};

    always_ff @(posedge clk)
    begin
        p1_reg <= p1_full[32:16];
        p2_reg <= p2_full[32:16];
        p3_reg <= p3_full[32] ? 16'hFFFF : p3_full[31:16];
    end

    // Stage 15: depth, raised height, and the flat-cell bypass
    assign depth_prod = p3_reg * 16'(MAX_DEPTH_UNITS);
    assign depth16    = depth_prod[31:16];
    assign depth      = depth16[15] ? 15'h7FFF : depth16[14:0];
    assign hsum       = 17'(aux_reg[10].h) + $signed({2'b00, depth});

    always_comb
    begin
        result_next.cell_temp  = aux_reg[10].temp;
        result_next.snow_cover = '0;
        result_next.snow_depth = '0;
        result_next.new_height = aux_reg[10].h;
        if (aux_reg[10].pos)
        begin
            result_next.snow_cover = p3_reg;
            result_next.snow_depth = depth;
            if (AFFECT_HEIGHT != 0)
                result_next.new_height = (hsum > 17'sd32767) ? 16'sd32767 : hsum[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg     <= result_next;
        result_pos_reg <= aux_reg[10].pos;
    end

    assign done   = vld_reg[PIPE_LAT];
    assign result = result_reg;

    `TSCC_ASSERT_NXT(a_accept_enters, accept, vld_reg[1], "accepted item missing in stage 1")
    `TSCC_ASSERT_IMP(a_flat_no_snow, done && !result_pos_reg, result.snow_cover == 16'd0 && result.snow_depth == 15'd0, "snow on a cell at or below zero height")
    `TSCC_ASSERT_IMP(a_depth_bound, done, 32'(result.snow_depth) <= 32'(MAX_DEPTH_UNITS), "snow depth above the maximum")
    `TSCC_ASSERT_IMP(a_height_rises, done, result.new_height >= $past(aux_reg[10].h), "raised height below the input height")

endmodule

FILE: sim/terrain_snow_cover_cell_unit_tb.sv
module terrain_snow_cover_cell_unit_tb;
    import tscc_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         start;
    logic         busy;
    cell_item_t   item;
    logic         done;
    cell_result_t result;
    logic         cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    terrain_snow_cover_cell_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Shadow copy of the register file, raw as written
    logic [15:0] sh_base_temp, sh_temp_drop, sh_shelter, sh_precip;
    logic [13:0] sh_snow_temp;
    logic [12:0] sh_trans_w;
    logic [14:0] sh_accum, sh_max_stable;

    cell_result_t expected_cells[$];
    int  mismatches;
    int  cells_checked;
    int  cells_sent;
    bit  quiet_mode;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint clampl(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Smoothstep in Q16, input clamped to [0, 1]
    function automatic longint smoothstep_q16(longint t);
        longint u;
        logic [63:0] w;
        u = clampl(t, 0, 65536);
        w = u * u * (196608 - 2 * u);
        return longint'(w >> 32);
    endfunction

    // Fraction of num over den in Q16, truncated toward zero, then offset and clamp
    function automatic longint frac_q16(longint num, longint den, longint offset);
        longint q;
        q = (num * 65536) / den;
        return clampl(q + offset, 0, 65536);
    endfunction

    function automatic cell_result_t predict_snow(cell_item_t c);
        cell_result_t r;
        longint h, slope, conc, drop, temp, tw, cold, ms, acc, span, stable;
        longint inner, shelter, p, depth, new_h;
        h     = longint'(c.height_sample);
        slope = longint'(c.slope_angle);
        conc  = longint'(c.concavity_value);
        // Round half up then floor: arithmetic shift of biased product
        drop  = (longint'(sh_temp_drop) * h + 16384) >>> 15;
        temp  = longint'($signed(sh_base_temp)) - drop;
        p     = 0;
        depth = 0;
        new_h = h;
        if (h > 0)
        begin
            tw   = (sh_trans_w < 26) ? 26 : longint'(sh_trans_w);
            cold = smoothstep_q16(frac_q16(longint'($signed(sh_snow_temp)) - temp, tw, 32768));
            ms   = clampl(longint'(sh_max_stable), 256, 22784);
            acc  = clampl(longint'(sh_accum), 0, ms);
            span = ms - acc;
            if (span < 256)
                span = 256;
            stable  = 65536 - smoothstep_q16(frac_q16(slope - acc, span, 0));
            inner   = (36045 * 32768 + 29491 * conc) >>> 15;
            shelter = 65536 - (((65536 - inner) * longint'(sh_shelter)) >>> 16);
            p = (cold * stable) >>> 16;
            p = (p * shelter) >>> 16;
            p = (p * longint'(sh_precip)) >>> 16;
            if (p > 65535)
                p = 65535;
            depth = (MAX_DEPTH_UNITS * p) >>> 16;
            if (depth > 32767)
                depth = 32767;
            if (AFFECT_HEIGHT != 0 && depth > 0)
                new_h = clampl(h + depth, -32768, 32767);
        end
        r.cell_temp  = temp[17:0];
        r.snow_cover = p[15:0];
        r.snow_depth = depth[14:0];
        r.new_height = new_h[15:0];
        return r;
    endfunction

    // Check every strobed result against the oldest prediction
    always @(posedge clk)
    begin
        cell_result_t want;
        if (rst_n && done)
        begin
            if (expected_cells.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result %h", result);
            end
            else
            begin
                want = expected_cells.pop_front();
                cells_checked++;
                if (result.cell_temp !== want.cell_temp
                    || result.snow_cover !== want.snow_cover
                    || result.snow_depth !== want.snow_depth
                    || result.new_height !== want.new_height)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: cell %0d temp %0d/%0d cover %0d/%0d depth %0d/%0d h %0d/%0d",
                            cells_checked, want.cell_temp, result.cell_temp,
                            want.snow_cover, result.snow_cover, want.snow_depth,
                            result.snow_depth, want.new_height, result.new_height);
                end
            end
        end
    end

    // Write one register and mirror it in the shadow copy, with cfg_we low again before the task returns
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_BASE_TEMP:        sh_base_temp  = value;
            REG_TEMP_DROP:        sh_temp_drop  = value;
            REG_SNOW_TEMP:        sh_snow_temp  = value[13:0];
            REG_TRANSITION_W:     sh_trans_w    = value[12:0];
            REG_ACCUM_SLOPE:      sh_accum      = value[14:0];
            REG_MAX_STABLE:       sh_max_stable = value[14:0];
            REG_SHELTER_STRENGTH: sh_shelter    = value;
            REG_PRECIPITATION:    sh_precip     = value;
            default: ;
        endcase
    endtask

    // Offer one item, hold start until accepted, record its prediction.
    // Start stays high into the next item when no gap follows.
    task automatic send_cell(cell_item_t c);
        int gap;
        start <= 1'b1;
        item  <= c;
        do
            @(posedge clk);
        while (busy);
        expected_cells.push_back(predict_snow(c));
        cells_sent++;
        if (!quiet_mode && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 14);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drain outstanding results before touching registers
    task automatic drain;
        start <= 1'b0;
        while (expected_cells.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 4) @(posedge clk);
    endtask

    function automatic cell_item_t rand_cell(bit full_slope);
        cell_item_t c;
        c.height_sample   = 16'($urandom);
        c.slope_angle     = full_slope ? 15'($urandom) : 15'($urandom_range(0, 23040));
        c.concavity_value = 16'($urandom);
        return c;
    endfunction

    function automatic cell_item_t make_cell(int h, int s, int cv);
        cell_item_t c;
        c.height_sample   = h[15:0];
        c.slope_angle     = s[14:0];
        c.concavity_value = cv[15:0];
        return c;
    endfunction

    task automatic test_directed;
        send_cell(make_cell(0, 0, 0));
        send_cell(make_cell(-32768, 23040, -32768));
        send_cell(make_cell(-1, 100, 5));
        send_cell(make_cell(1, 0, 32767));
        send_cell(make_cell(32767, 0, 32767));
        send_cell(make_cell(32767, 23040, -32768));
        send_cell(make_cell(32767, 32767, 0));
        send_cell(make_cell(16384, 5632, 0));
        send_cell(make_cell(16384, 12288, 0));
        send_cell(make_cell(8000, 8000, -32768));
        send_cell(make_cell(32000, 0, 32767));
        send_cell(make_cell(200, 1000, 1000));
    endtask

    // Cold, flat, sheltered set: deep snow, height overflow, narrow transitions; then a warm, dry set
    task automatic test_extreme_config;
        drain();
        write_reg(REG_BASE_TEMP, 16'(-20480));
        write_reg(REG_TEMP_DROP, 16'd0);
        write_reg(REG_SNOW_TEMP, 16'd2560);
        write_reg(REG_TRANSITION_W, 16'd3);
        write_reg(REG_ACCUM_SLOPE, 16'd30000);
        write_reg(REG_MAX_STABLE, 16'd100);
        write_reg(REG_SHELTER_STRENGTH, 16'd65535);
        write_reg(REG_PRECIPITATION, 16'd65535);
        write_reg(4'd12, 16'hBEEF);
        send_cell(make_cell(32767, 0, 32767));
        send_cell(make_cell(32760, 255, 32767));
        send_cell(make_cell(1, 300, -32768));
        send_cell(make_cell(100, 32767, 0));
        drain();
        write_reg(REG_BASE_TEMP, 16'd15360);
        write_reg(REG_TEMP_DROP, 16'd51200);
        write_reg(REG_SNOW_TEMP, 16'(-5120));
        write_reg(REG_TRANSITION_W, 16'd7680);
        write_reg(REG_ACCUM_SLOPE, 16'd0);
        write_reg(REG_MAX_STABLE, 16'd32767);
        write_reg(REG_SHELTER_STRENGTH, 16'd0);
        write_reg(REG_PRECIPITATION, 16'd0);
        send_cell(make_cell(32767, 0, 0));
        send_cell(make_cell(-32768, 0, 0));
        send_cell(make_cell(16000, 20000, 100));
    endtask

    // Random register sets, each followed by a batch of random cells
    task automatic test_random(int phases, int per_phase);
        for (int ph = 0; ph < phases; ph++)
        begin
            drain();
            write_reg(REG_BASE_TEMP, 16'($urandom_range(0, 35840) - 20480));
            write_reg(REG_TEMP_DROP, 16'($urandom_range(0, 51200)));
            write_reg(REG_SNOW_TEMP, 16'($urandom_range(0, 7680) - 5120));
            write_reg(REG_TRANSITION_W, 16'($urandom_range(0, 8191)));
            write_reg(REG_ACCUM_SLOPE, 16'($urandom_range(0, 32767)));
            write_reg(REG_MAX_STABLE, 16'($urandom_range(0, 32767)));
            write_reg(REG_SHELTER_STRENGTH, 16'($urandom));
            write_reg(REG_PRECIPITATION, 16'($urandom));
            for (int i = 0; i < per_phase; i++)
                send_cell(rand_cell($urandom_range(0, 9) == 0));
        end
    endtask

    // Back-to-back cells with start held high throughout
    task automatic test_streaming;
        quiet_mode = 1'b1;
        for (int i = 0; i < 200; i++)
            send_cell(rand_cell(1'b0));
        quiet_mode = 1'b0;
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        item       = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        mismatches = 0;
        cells_checked = 0;
        cells_sent = 0;
        quiet_mode = 1'b0;
        sh_base_temp  = 16'd3072;
        sh_temp_drop  = 16'd16640;
        sh_snow_temp  = 14'd384;
        sh_trans_w    = 13'd1024;
        sh_accum      = 15'd5632;
        sh_max_stable = 15'd12288;
        sh_shelter    = 16'd29491;
        sh_precip     = 16'd52429;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_extreme_config();
        test_random(10, 100);
        drain();
        test_streaming();

        drain();
        $display("Covered %0d cells over default, extreme and random register sets; %0d checked.",
            cells_sent, cells_checked);
        if (mismatches == 0 && expected_cells.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Hard stop far beyond the slowest correct run
    initial
    begin
        #400000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
